/* src/cpws_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package cpws_pkg;

  // coordinate width kept in the address cache and sent on the bus
  localparam int unsigned COORD_BITS = 12;

  // depth of the queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;

  // display command codes
  localparam logic [7:0] CMD_COLUMN = 8'h2A;
  localparam logic [7:0] CMD_ROW    = 8'h2B;
  localparam logic [7:0] CMD_WRITE  = 8'h2C;

  // register indexes on the configuration port
  localparam logic [2:0] REG_X_DATUM = 3'd0;
  localparam logic [2:0] REG_Y_DATUM = 3'd1;
  localparam logic [2:0] REG_VP_X    = 3'd2;
  localparam logic [2:0] REG_VP_Y    = 3'd3;
  localparam logic [2:0] REG_VP_W    = 3'd4;
  localparam logic [2:0] REG_VP_H    = 3'd5;
  localparam logic [2:0] REG_VP_OFF  = 3'd6;

  // request types
  localparam logic REQ_PIXEL      = 1'b0;
  localparam logic REQ_INVALIDATE = 1'b1;

  // configuration seen by the front
  typedef struct packed {
    logic signed [12:0] x_datum;
    logic signed [12:0] y_datum;
    logic [11:0]        vp_x;
    logic [11:0]        vp_y;
    logic [12:0]        vp_w;
    logic [12:0]        vp_h;
    logic               vp_off;
  } cfg_t;

  // one classified pixel waiting in the queue
  typedef struct packed {
    logic                  need_col;
    logic                  need_row;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [15:0]           colour;
  } entry_t;

endpackage
`default_nettype wire

/* src/cpws_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
module cpws_regs (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cpws_pkg::cfg_t     cfg_o
);

  cpws_pkg::cfg_t cfg_q;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_datum <= '0;
      cfg_q.y_datum <= '0;
      cfg_q.vp_x    <= '0;
      cfg_q.vp_y    <= '0;
      cfg_q.vp_w    <= 13'd4096;
      cfg_q.vp_h    <= 13'd4096;
      cfg_q.vp_off  <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        cpws_pkg::REG_X_DATUM: cfg_q.x_datum <= $signed(pwdata[12:0]);
        cpws_pkg::REG_Y_DATUM: cfg_q.y_datum <= $signed(pwdata[12:0]);
        cpws_pkg::REG_VP_X:    cfg_q.vp_x    <= pwdata[11:0];
        cpws_pkg::REG_VP_Y:    cfg_q.vp_y    <= pwdata[11:0];
        cpws_pkg::REG_VP_W:    cfg_q.vp_w    <= pwdata[12:0];
        cpws_pkg::REG_VP_H:    cfg_q.vp_h    <= pwdata[12:0];
        cpws_pkg::REG_VP_OFF:  cfg_q.vp_off  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      cpws_pkg::REG_X_DATUM: prdata = {19'd0, cfg_q.x_datum};
      cpws_pkg::REG_Y_DATUM: prdata = {19'd0, cfg_q.y_datum};
      cpws_pkg::REG_VP_X:    prdata = {20'd0, cfg_q.vp_x};
      cpws_pkg::REG_VP_Y:    prdata = {20'd0, cfg_q.vp_y};
      cpws_pkg::REG_VP_W:    prdata = {19'd0, cfg_q.vp_w};
      cpws_pkg::REG_VP_H:    prdata = {19'd0, cfg_q.vp_h};
      cpws_pkg::REG_VP_OFF:  prdata = {31'd0, cfg_q.vp_off};
      default:               prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* src/cpws_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module cpws_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cpws_pkg::cfg_t      cfg_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                req_type_i,
  input  wire logic signed [15:0]  pixel_x_i,
  input  wire logic signed [15:0]  pixel_y_i,
  input  wire logic [15:0]         colour_i,
  input  wire logic                q_full_i,
  output logic                     push_o,
  output cpws_pkg::entry_t         entry_o
);

  logic signed [16:0]                x_sum;
  logic signed [16:0]                y_sum;
  logic                              in_box;
  logic                              keep;
  logic                              accept;
  logic [cpws_pkg::COORD_BITS-1:0]   cx;
  logic [cpws_pkg::COORD_BITS-1:0]   cy;
  logic                              need_col;
  logic                              need_row;

  logic [cpws_pkg::COORD_BITS-1:0]   col_q, col_d;
  logic [cpws_pkg::COORD_BITS-1:0]   row_q, row_d;
  logic                              col_known_q, col_known_d;
  logic                              row_known_q, row_known_d;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // datum offset
  assign x_sum = $signed({pixel_x_i[15], pixel_x_i}) +
                 $signed({{4{cfg_i.x_datum[12]}}, cfg_i.x_datum});
  assign y_sum = $signed({pixel_y_i[15], pixel_y_i}) +
                 $signed({{4{cfg_i.y_datum[12]}}, cfg_i.y_datum});

  // viewport clip, half-open box
  assign in_box = (x_sum >= $signed({5'd0, cfg_i.vp_x})) &&
                  (y_sum >= $signed({5'd0, cfg_i.vp_y})) &&
                  (x_sum <  $signed({4'd0, cfg_i.vp_w})) &&
                  (y_sum <  $signed({4'd0, cfg_i.vp_h}));
  assign keep   = !cfg_i.vp_off && in_box;

  assign cx = x_sum[cpws_pkg::COORD_BITS-1:0];
  assign cy = y_sum[cpws_pkg::COORD_BITS-1:0];

  // address cache compare
  assign need_col = !col_known_q || (col_q != cx);
  assign need_row = !row_known_q || (row_q != cy);

  assign push_o          = accept && (req_type_i == cpws_pkg::REQ_PIXEL) && keep;
  assign entry_o.need_col = need_col;
  assign entry_o.need_row = need_row;
  assign entry_o.cx       = cx;
  assign entry_o.cy       = cy;
  assign entry_o.colour   = colour_i;

  // cache update
  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    col_known_d = col_known_q;
    row_known_d = row_known_q;
    if (accept && (req_type_i == cpws_pkg::REQ_INVALIDATE)) begin
      col_known_d = 1'b0;
      row_known_d = 1'b0;
    end else if (push_o) begin
      col_d       = cx;
      row_d       = cy;
      col_known_d = 1'b1;
      row_known_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      col_known_q <= 1'b0;
      row_known_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      col_known_q <= col_known_d;
      row_known_q <= row_known_d;
    end
  end

endmodule
`default_nettype wire

/* src/cpws_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
module cpws_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire cpws_pkg::entry_t  wdata_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output cpws_pkg::entry_t       rdata_o,
  output logic                   empty_o
);

  localparam int unsigned PTR_W = $clog2(cpws_pkg::FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(cpws_pkg::FIFO_DEPTH + 1);

  cpws_pkg::entry_t   mem_q [cpws_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]   wptr_q, wptr_d;
  logic [PTR_W-1:0]   rptr_q, rptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(cpws_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  // pointer and fill count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PTR_W'(cpws_pkg::FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PTR_W'(cpws_pkg::FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // front must hold off while full, back must not pop an empty queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(cpws_pkg::FIFO_DEPTH)) else $error("queue count overflow");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> !empty_o) else $error("queue lost an entry");

endmodule
`default_nettype wire

/* src/cpws_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module cpws_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cpws_pkg::entry_t  head_i,
  input  wire logic              empty_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   is_data_o,
  output logic [2:0]             byte_count_o,
  output logic [31:0]            bus_word_o,
  output logic                   last_o
);

  // word steps of one pixel
  localparam logic [2:0] ST_COL_CMD  = 3'd0;
  localparam logic [2:0] ST_COL_DATA = 3'd1;
  localparam logic [2:0] ST_ROW_CMD  = 3'd2;
  localparam logic [2:0] ST_ROW_DATA = 3'd3;
  localparam logic [2:0] ST_WR_CMD   = 3'd4;
  localparam logic [2:0] ST_WR_DATA  = 3'd5;

  logic [2:0]  step_q, step_d;
  logic [2:0]  eff;
  logic        load;
  logic        valid_q, valid_d;
  logic        is_data_q, is_data_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] word_q, word_d;
  logic        last_q, last_d;
  logic [15:0] cx16;
  logic [15:0] cy16;

  assign cx16 = 16'(head_i.cx);
  assign cy16 = 16'(head_i.cy);

  assign load = !empty_i && (!valid_q || out_ready_i);

  // skip address steps that hit the cache
  always_comb begin
    unique case (step_q)
      ST_COL_CMD:  eff = head_i.need_col ? ST_COL_CMD :
                         (head_i.need_row ? ST_ROW_CMD : ST_WR_CMD);
      ST_ROW_CMD:  eff = head_i.need_row ? ST_ROW_CMD : ST_WR_CMD;
      default:     eff = step_q;
    endcase
  end

  // bus word for the current step
  always_comb begin
    is_data_d = 1'b0;
    cnt_d     = 3'd1;
    word_d    = '0;
    last_d    = 1'b0;
    unique case (eff)
      ST_COL_CMD:  word_d = {24'd0, cpws_pkg::CMD_COLUMN};
      ST_COL_DATA: begin
        is_data_d = 1'b1;
        cnt_d     = 3'd4;
        word_d    = {cx16, cx16};
      end
      ST_ROW_CMD:  word_d = {24'd0, cpws_pkg::CMD_ROW};
      ST_ROW_DATA: begin
        is_data_d = 1'b1;
        cnt_d     = 3'd4;
        word_d    = {cy16, cy16};
      end
      ST_WR_CMD:   word_d = {24'd0, cpws_pkg::CMD_WRITE};
      default: begin
        is_data_d = 1'b1;
        cnt_d     = 3'd2;
        word_d    = {16'd0, head_i.colour};
        last_d    = 1'b1;
      end
    endcase
  end

  // step sequencing and output register valid
  always_comb begin
    step_d  = step_q;
    pop_o   = 1'b0;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      if (eff == ST_WR_DATA) begin
        step_d = ST_COL_CMD;
        pop_o  = 1'b1;
      end else begin
        step_d = eff + 3'd1;
      end
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= ST_COL_CMD;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      is_data_q <= is_data_d;
      cnt_q     <= cnt_d;
      word_q    <= word_d;
      last_q    <= last_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign is_data_o    = is_data_q;
  assign byte_count_o = cnt_q;
  assign bus_word_o   = word_q;
  assign last_o       = last_q;

endmodule
`default_nettype wire

/* src/clipped_pixel_write_sequencer_unit.sv */
// an accepted pixel is written into the queue, then into the output register
// throughput: one bus word per cycle while out_ready_i is high and the queue is
//   not empty, so a pixel is 2 bus words when both addresses hit the cache,
//   4 or 6 when they miss; invalidates and clipped pixels produce no bus word
// reset: registers return to reset values, address cache empty, queue empty
`timescale 1ns / 1ps
`default_nettype none
module clipped_pixel_write_sequencer_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               req_type_i,
  input  wire logic signed [15:0] pixel_x_i,
  input  wire logic signed [15:0] pixel_y_i,
  input  wire logic [15:0]        colour_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    is_data_o,
  output logic [2:0]              byte_count_o,
  output logic [31:0]             bus_word_o,
  output logic                    last_o
);

  cpws_pkg::cfg_t   cfg;
  cpws_pkg::entry_t push_entry;
  cpws_pkg::entry_t head_entry;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;

  // configuration registers
  cpws_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // offset, clip and cache classification
  cpws_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .colour_i   (colour_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // queue between front and back
  cpws_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .rdata_o (head_entry),
    .empty_o (q_empty)
  );

  // bus word sequencer
  cpws_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_entry),
    .empty_i      (q_empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .is_data_o    (is_data_o),
    .byte_count_o (byte_count_o),
    .bus_word_o   (bus_word_o),
    .last_o       (last_o)
  );

endmodule
`default_nettype wire
